@@ hdl/alpha_instruction_decoder_top_defines.svh @@
// assertion macros used by the decoder top
`ifndef ALPHA_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define ALPHA_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define AID_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define AID_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ hdl/aid_pkg.sv @@
`default_nettype none
package aid_pkg;

  // instruction classes
  localparam logic [2:0] KIND_UNDEF  = 3'd0;
  localparam logic [2:0] KIND_JUMP   = 3'd1;
  localparam logic [2:0] KIND_MEM    = 3'd2;
  localparam logic [2:0] KIND_BRANCH = 3'd3;
  localparam logic [2:0] KIND_INT    = 3'd4;
  localparam logic [2:0] KIND_FP     = 3'd5;

  // mnemonic numbers
  localparam logic [7:0] MN_UNDEF     = 8'd0;
  localparam logic [7:0] MN_JMP       = 8'd1;
  localparam logic [7:0] MN_TRAPB     = 8'd5;
  localparam logic [7:0] MN_NOP       = 8'd6;
  localparam logic [7:0] MN_CLR       = 8'd7;
  localparam logic [7:0] MN_MOV       = 8'd8;
  localparam logic [7:0] MN_FNOP      = 8'd9;
  localparam logic [7:0] MN_FMOV      = 8'd10;
  localparam logic [7:0] MN_FP_UNKN   = 8'd11;
  localparam logic [7:0] MN_PRIM_BASE = 8'd16;
  localparam logic [7:0] MN_TBL_BASE  = 8'd80;

  // opcodes and functions used by the alias rules
  localparam logic [5:0]  OP_MISC  = 6'h18;
  localparam logic [5:0]  OP_INTL  = 6'h11;
  localparam logic [5:0]  OP_FLTL  = 6'h17;
  localparam logic [6:0]  FN_BIS   = 7'h20;
  localparam logic [10:0] FN_CPYS  = 11'h020;
  localparam logic [4:0]  REG_ZERO = 5'd31;

  // class of each primary opcode
  localparam logic [2:0] CLASS_MAP [64] = '{
    KIND_UNDEF, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_UNDEF, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_INT, KIND_INT, KIND_INT, KIND_INT,
    KIND_UNDEF, KIND_UNDEF, KIND_FP, KIND_FP,
    KIND_MEM, KIND_UNDEF, KIND_JUMP, KIND_UNDEF,
    KIND_INT, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH
  };

  // operate table, each entry is {opcode, function}
  localparam int TBL_LEN   = 103;
  localparam int TBL_IDX_W = $clog2(TBL_LEN);

  localparam logic [16:0] OPER_TBL [TBL_LEN] = '{
    {6'h10, 11'h000}, {6'h10, 11'h040}, {6'h10, 11'h020}, {6'h10, 11'h060},
    {6'h10, 11'h009}, {6'h10, 11'h049}, {6'h10, 11'h029}, {6'h10, 11'h069},
    {6'h10, 11'h02d}, {6'h10, 11'h04d}, {6'h10, 11'h06d}, {6'h10, 11'h01d},
    {6'h10, 11'h03d}, {6'h10, 11'h00f}, {6'h10, 11'h002}, {6'h10, 11'h00b},
    {6'h10, 11'h022}, {6'h10, 11'h02b}, {6'h10, 11'h012}, {6'h10, 11'h01b},
    {6'h10, 11'h032}, {6'h10, 11'h03b},
    {6'h11, 11'h000}, {6'h11, 11'h020}, {6'h11, 11'h040}, {6'h11, 11'h008},
    {6'h11, 11'h028}, {6'h11, 11'h048}, {6'h11, 11'h024}, {6'h11, 11'h044},
    {6'h11, 11'h064}, {6'h11, 11'h026}, {6'h11, 11'h046}, {6'h11, 11'h066},
    {6'h11, 11'h014}, {6'h11, 11'h016},
    {6'h12, 11'h039}, {6'h12, 11'h03c}, {6'h12, 11'h034}, {6'h12, 11'h030},
    {6'h12, 11'h031}, {6'h12, 11'h006}, {6'h12, 11'h016}, {6'h12, 11'h026},
    {6'h12, 11'h036}, {6'h12, 11'h05a}, {6'h12, 11'h06a}, {6'h12, 11'h07a},
    {6'h12, 11'h00b}, {6'h12, 11'h01b}, {6'h12, 11'h02b}, {6'h12, 11'h03b},
    {6'h12, 11'h057}, {6'h12, 11'h067}, {6'h12, 11'h077}, {6'h12, 11'h002},
    {6'h12, 11'h012}, {6'h12, 11'h022}, {6'h12, 11'h032}, {6'h12, 11'h052},
    {6'h12, 11'h062}, {6'h12, 11'h072},
    {6'h13, 11'h000}, {6'h13, 11'h020}, {6'h13, 11'h040}, {6'h13, 11'h060},
    {6'h13, 11'h030},
    {6'h16, 11'h080}, {6'h16, 11'h0a0}, {6'h16, 11'h081}, {6'h16, 11'h0a1},
    {6'h16, 11'h082}, {6'h16, 11'h0a2}, {6'h16, 11'h083}, {6'h16, 11'h0a3},
    {6'h16, 11'h580}, {6'h16, 11'h5a0}, {6'h16, 11'h581}, {6'h16, 11'h5a1},
    {6'h16, 11'h582}, {6'h16, 11'h5a2}, {6'h16, 11'h583}, {6'h16, 11'h5a3},
    {6'h16, 11'h0ac}, {6'h16, 11'h0bc}, {6'h16, 11'h0be}, {6'h16, 11'h0af},
    {6'h16, 11'h02f}, {6'h16, 11'h5ac}, {6'h16, 11'h5af}, {6'h16, 11'h52f},
    {6'h16, 11'h0a4}, {6'h16, 11'h0a5}, {6'h16, 11'h0a6}, {6'h16, 11'h0a7},
    {6'h16, 11'h5a4}, {6'h16, 11'h5a5}, {6'h16, 11'h5a6}, {6'h16, 11'h5a7},
    {6'h17, 11'h020}, {6'h17, 11'h021},
    {6'h1c, 11'h000}, {6'h1c, 11'h001}
  };

  // result of a table search
  typedef struct packed {
    logic                 hit;
    logic [TBL_IDX_W-1:0] idx;
  } match_t;

endpackage
`default_nettype wire

@@ hdl/alpha_instruction_decoder_top.sv @@
// throughput: one instruction word per cycle while out_ready is not held low, through three register stages
// stage 1 captures the word, stage 2 holds the class, alias mnemonic and branch target,
// stage 3 holds the operate table match and the final field selection
// reset: synchronous active-low rst_n clears the three stage valid bits only
`default_nettype none
`include "alpha_instruction_decoder_top_defines.svh"
module alpha_instruction_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [31:0]        in_instr_word,
  input  wire logic [31:0]        in_position,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_kind,
  output      logic [7:0]         out_mnemonic,
  output      logic [4:0]         out_reg_a,
  output      logic [4:0]         out_reg_b,
  output      logic [4:0]         out_reg_c,
  output      logic               out_uses_literal,
  output      logic [7:0]         out_literal,
  output      logic [10:0]        out_func_code,
  output      logic signed [15:0] out_displacement,
  output      logic [31:0]        out_branch_target
);
  import aid_pkg::*;

  // stage enables, a stage loads when empty or when its word moves on
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: capture the raw word
  logic [31:0] w1_r, pos1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      w1_r   <= in_instr_word;
      pos1_r <= in_position;
    end
  end

  // stage 1 to 2: classify, alias rules, table key, branch target
  logic [5:0]  op1;
  logic [4:0]  ra1, rb1, rc1;
  logic [2:0]  kind1;
  logic [10:0] key1;
  logic [7:0]  pre_mn1, miss_mn1;
  logic        use_tbl1;
  logic [31:0] tgt1;

  assign op1   = w1_r[31:26];
  assign ra1   = w1_r[25:21];
  assign rb1   = w1_r[20:16];
  assign rc1   = w1_r[4:0];
  assign kind1 = CLASS_MAP[op1];
  assign key1  = (kind1 == KIND_FP) ? w1_r[15:5] : {4'b0000, w1_r[11:5]};
  assign tgt1  = pos1_r + 32'd4 + {{9{w1_r[20]}}, w1_r[20:0], 2'b00};

  always_comb begin
    pre_mn1  = MN_UNDEF;
    miss_mn1 = MN_UNDEF;
    use_tbl1 = 1'b0;
    unique case (kind1)
      KIND_JUMP: begin
        pre_mn1 = MN_JMP + {6'b000000, w1_r[15:14]};
      end
      KIND_MEM: begin
        if (op1 == OP_MISC && ra1 == 5'd0 && rb1 == 5'd0 && w1_r[15:0] == 16'd0) begin
          pre_mn1 = MN_TRAPB;
        end else begin
          pre_mn1 = MN_PRIM_BASE + {2'b00, op1};
        end
      end
      KIND_BRANCH: begin
        pre_mn1 = MN_PRIM_BASE + {2'b00, op1};
      end
      KIND_FP: begin
        miss_mn1 = MN_FP_UNKN;
        if (op1 == OP_FLTL && w1_r[15:5] == FN_CPYS && ra1 == rb1) begin
          pre_mn1 = (ra1 == REG_ZERO && rc1 == REG_ZERO) ? MN_FNOP : MN_FMOV;
        end else begin
          use_tbl1 = 1'b1;
        end
      end
      KIND_INT: begin
        if (op1 == OP_INTL && w1_r[11:5] == FN_BIS && ra1 == rb1 && !w1_r[12]) begin
          priority if (ra1 == REG_ZERO && rc1 == REG_ZERO) begin
            pre_mn1 = MN_NOP;
          end else if (ra1 == REG_ZERO) begin
            pre_mn1 = MN_CLR;
          end else begin
            pre_mn1 = MN_MOV;
          end
        end else begin
          use_tbl1 = 1'b1;
        end
      end
      default: begin
        pre_mn1 = MN_UNDEF;
      end
    endcase
  end

  // stage 2 registers
  logic [31:0] w2_r, tgt2_r;
  logic [2:0]  kind2_r;
  logic [10:0] key2_r;
  logic [7:0]  pre_mn2_r, miss_mn2_r;
  logic        use_tbl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      w2_r       <= w1_r;
      tgt2_r     <= tgt1;
      kind2_r    <= kind1;
      key2_r     <= key1;
      pre_mn2_r  <= pre_mn1;
      miss_mn2_r <= miss_mn1;
      use_tbl2_r <= use_tbl1;
    end
  end

  // stage 2 to 3: operate table search and field selection
  match_t m2;

  aid_match u_match (
    .op  (w2_r[31:26]),
    .fn  (key2_r),
    .res (m2)
  );

  logic [7:0]  mn_nxt;
  logic [4:0]  rb_nxt, rc_nxt;
  logic        ls_nxt;
  logic [7:0]  lit_nxt;
  logic [10:0] fn_nxt;
  logic [15:0] disp_nxt;
  logic [31:0] tgt_nxt;

  always_comb begin
    if (use_tbl2_r) begin
      mn_nxt = m2.hit ? (MN_TBL_BASE + {1'b0, m2.idx}) : miss_mn2_r;
    end else begin
      mn_nxt = pre_mn2_r;
    end
  end

  always_comb begin
    rb_nxt   = 5'd0;
    rc_nxt   = 5'd0;
    ls_nxt   = 1'b0;
    lit_nxt  = 8'd0;
    fn_nxt   = 11'd0;
    disp_nxt = 16'd0;
    tgt_nxt  = 32'd0;
    unique case (kind2_r)
      KIND_JUMP: begin
        rb_nxt = w2_r[20:16];
      end
      KIND_MEM: begin
        rb_nxt   = w2_r[20:16];
        disp_nxt = w2_r[15:0];
      end
      KIND_BRANCH: begin
        tgt_nxt = tgt2_r;
      end
      KIND_FP: begin
        rb_nxt = w2_r[20:16];
        rc_nxt = w2_r[4:0];
        fn_nxt = w2_r[15:5];
      end
      default: begin
        // integer operate and undefined opcodes
        rc_nxt = w2_r[4:0];
        ls_nxt = w2_r[12];
        fn_nxt = {4'b0000, w2_r[11:5]};
        if (w2_r[12]) begin
          lit_nxt = w2_r[20:13];
        end else begin
          rb_nxt = w2_r[20:16];
        end
      end
    endcase
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_kind          <= kind2_r;
      out_mnemonic      <= mn_nxt;
      out_reg_a         <= w2_r[25:21];
      out_reg_b         <= rb_nxt;
      out_reg_c         <= rc_nxt;
      out_uses_literal  <= ls_nxt;
      out_literal       <= lit_nxt;
      out_func_code     <= fn_nxt;
      out_displacement  <= disp_nxt;
      out_branch_target <= tgt_nxt;
    end
  end

  assign out_valid = v3_r;

  // per-kind properties of the output word
  logic chk_fp_named, chk_undef_mn, chk_branch_fields;

  assign chk_fp_named      = !(out_valid && out_kind == KIND_FP) || out_mnemonic != MN_UNDEF;
  assign chk_undef_mn      = !(out_valid && out_kind == KIND_UNDEF) || out_mnemonic == MN_UNDEF;
  assign chk_branch_fields = !(out_valid && out_kind == KIND_BRANCH) ||
                             (out_displacement == 16'sd0 && out_reg_b == 5'd0);

  // checks on the decode and the stage handshake
  `AID_ASSERT_NOW(a_fp_named, chk_fp_named, "floating word without mnemonic")
  `AID_ASSERT_NOW(a_undef_mn, chk_undef_mn, "undefined opcode got a mnemonic")
  `AID_ASSERT_NOW(a_branch_fields, chk_branch_fields, "branch carries memory fields")
  `AID_ASSERT_NEXT(a_s1_hold, v1_r && !en2, v1_r && $stable(w1_r), "stage 1 word lost")
  `AID_ASSERT_NEXT(a_s2_hold, v2_r && !en3, v2_r && $stable(w2_r), "stage 2 word lost")

endmodule
`default_nettype wire

@@ hdl/aid_match.sv @@
`default_nettype none
module aid_match (
  input  wire logic [5:0]      op,
  input  wire logic [10:0]     fn,
  output aid_pkg::match_t      res
);
  import aid_pkg::*;

  // parallel compare of every entry, lowest index wins
  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = TBL_LEN - 1; i >= 0; i--) begin
      if (OPER_TBL[i] == {op, fn}) begin
        res.hit = 1'b1;
        res.idx = TBL_IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/alpha_instruction_decoder_top_test.sv @@
module alpha_instruction_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aid_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int RANDOM_WORDS = 1550;
  localparam int PIPE_DEPTH   = 3;
  localparam int NUM_ENTRIES  = 103;

  // class of each primary opcode
  localparam logic [2:0] OPCODE_KIND [64] = '{
    KIND_UNDEF, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_UNDEF, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_INT, KIND_INT, KIND_INT, KIND_INT,
    KIND_UNDEF, KIND_UNDEF, KIND_FP, KIND_FP,
    KIND_MEM, KIND_UNDEF, KIND_JUMP, KIND_UNDEF,
    KIND_INT, KIND_UNDEF, KIND_UNDEF, KIND_UNDEF,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_MEM, KIND_MEM, KIND_MEM, KIND_MEM,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH,
    KIND_BRANCH, KIND_BRANCH, KIND_BRANCH, KIND_BRANCH
  };

  // {opcode, function} pairs of the operate mnemonics, in mnemonic order
  localparam logic [16:0] DECODE_TBL [NUM_ENTRIES] = '{
    {6'h10, 11'h000}, {6'h10, 11'h040}, {6'h10, 11'h020}, {6'h10, 11'h060},
    {6'h10, 11'h009}, {6'h10, 11'h049}, {6'h10, 11'h029}, {6'h10, 11'h069},
    {6'h10, 11'h02d}, {6'h10, 11'h04d}, {6'h10, 11'h06d}, {6'h10, 11'h01d},
    {6'h10, 11'h03d}, {6'h10, 11'h00f}, {6'h10, 11'h002}, {6'h10, 11'h00b},
    {6'h10, 11'h022}, {6'h10, 11'h02b}, {6'h10, 11'h012}, {6'h10, 11'h01b},
    {6'h10, 11'h032}, {6'h10, 11'h03b},
    {6'h11, 11'h000}, {6'h11, 11'h020}, {6'h11, 11'h040}, {6'h11, 11'h008},
    {6'h11, 11'h028}, {6'h11, 11'h048}, {6'h11, 11'h024}, {6'h11, 11'h044},
    {6'h11, 11'h064}, {6'h11, 11'h026}, {6'h11, 11'h046}, {6'h11, 11'h066},
    {6'h11, 11'h014}, {6'h11, 11'h016},
    {6'h12, 11'h039}, {6'h12, 11'h03c}, {6'h12, 11'h034}, {6'h12, 11'h030},
    {6'h12, 11'h031}, {6'h12, 11'h006}, {6'h12, 11'h016}, {6'h12, 11'h026},
    {6'h12, 11'h036}, {6'h12, 11'h05a}, {6'h12, 11'h06a}, {6'h12, 11'h07a},
    {6'h12, 11'h00b}, {6'h12, 11'h01b}, {6'h12, 11'h02b}, {6'h12, 11'h03b},
    {6'h12, 11'h057}, {6'h12, 11'h067}, {6'h12, 11'h077}, {6'h12, 11'h002},
    {6'h12, 11'h012}, {6'h12, 11'h022}, {6'h12, 11'h032}, {6'h12, 11'h052},
    {6'h12, 11'h062}, {6'h12, 11'h072},
    {6'h13, 11'h000}, {6'h13, 11'h020}, {6'h13, 11'h040}, {6'h13, 11'h060},
    {6'h13, 11'h030},
    {6'h16, 11'h080}, {6'h16, 11'h0a0}, {6'h16, 11'h081}, {6'h16, 11'h0a1},
    {6'h16, 11'h082}, {6'h16, 11'h0a2}, {6'h16, 11'h083}, {6'h16, 11'h0a3},
    {6'h16, 11'h580}, {6'h16, 11'h5a0}, {6'h16, 11'h581}, {6'h16, 11'h5a1},
    {6'h16, 11'h582}, {6'h16, 11'h5a2}, {6'h16, 11'h583}, {6'h16, 11'h5a3},
    {6'h16, 11'h0ac}, {6'h16, 11'h0bc}, {6'h16, 11'h0be}, {6'h16, 11'h0af},
    {6'h16, 11'h02f}, {6'h16, 11'h5ac}, {6'h16, 11'h5af}, {6'h16, 11'h52f},
    {6'h16, 11'h0a4}, {6'h16, 11'h0a5}, {6'h16, 11'h0a6}, {6'h16, 11'h0a7},
    {6'h16, 11'h5a4}, {6'h16, 11'h5a5}, {6'h16, 11'h5a6}, {6'h16, 11'h5a7},
    {6'h17, 11'h020}, {6'h17, 11'h021},
    {6'h1c, 11'h000}, {6'h1c, 11'h001}
  };

  // one decoded instruction as seen on the result port
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  mnem;
    logic [4:0]  reg_a;
    logic [4:0]  reg_b;
    logic [4:0]  reg_c;
    logic        uses_lit;
    logic [7:0]  lit;
    logic [10:0] func;
    logic [15:0] disp;
    logic [31:0] target;
  } decoded_t;

  // decode predictor and in-order result checker
  class decode_scoreboard;
    decoded_t pending[$];
    int       mismatches;
    int       words_seen;
    int       kind_count[8];
    int       mnem_count[16];
    int       int_no_match;

    function int find_entry(logic [5:0] op, logic [10:0] fn);
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (DECODE_TBL[i] == {op, fn}) return i;
      return -1;
    endfunction

    function decoded_t decode_word(logic [31:0] w, logic [31:0] pos);
      decoded_t    d;
      logic [5:0]  op;
      logic [4:0]  ra, rb, rc;
      logic [6:0]  fn7;
      logic [10:0] fn11;
      logic [31:0] offset;
      int          idx;
      op   = w[31:26];
      ra   = w[25:21];
      rb   = w[20:16];
      rc   = w[4:0];
      fn7  = w[11:5];
      fn11 = w[15:5];
      d    = '0;
      d.kind = OPCODE_KIND[op];
      case (d.kind)
        KIND_JUMP: begin
          d.mnem  = MN_JMP + {6'b0, w[15:14]};
          d.reg_a = ra;
          d.reg_b = rb;
        end
        KIND_MEM: begin
          // trap barrier is the all-zero misc form
          if (op == OP_MISC && ra == 5'd0 && rb == 5'd0 && w[15:0] == 16'd0)
            d.mnem = MN_TRAPB;
          else
            d.mnem = MN_PRIM_BASE + {2'b0, op};
          d.reg_a = ra;
          d.reg_b = rb;
          d.disp  = w[15:0];
        end
        KIND_BRANCH: begin
          offset   = {{11{w[20]}}, w[20:0]};
          d.target = pos + 32'd4 + (offset << 2);
          d.mnem   = MN_PRIM_BASE + {2'b0, op};
          d.reg_a  = ra;
        end
        KIND_FP: begin
          if (op == OP_FLTL && fn11 == FN_CPYS && ra == rb) begin
            d.mnem = (ra == REG_ZERO && rc == REG_ZERO) ? MN_FNOP : MN_FMOV;
          end else begin
            idx = find_entry(op, fn11);
            d.mnem = (idx < 0) ? MN_FP_UNKN : MN_TBL_BASE + 8'(idx);
          end
          d.reg_a = ra;
          d.reg_b = rb;
          d.reg_c = rc;
          d.func  = fn11;
        end
        default: begin
          if (d.kind == KIND_INT) begin
            // integer or-forms with equal registers become nop / clr / mov
            if (op == OP_INTL && fn7 == FN_BIS && ra == rb && !w[12]) begin
              if (ra == REG_ZERO && rc == REG_ZERO) d.mnem = MN_NOP;
              else if (ra == REG_ZERO)              d.mnem = MN_CLR;
              else                                  d.mnem = MN_MOV;
            end else begin
              idx = find_entry(op, {4'b0, fn7});
              d.mnem = (idx < 0) ? MN_UNDEF : MN_TBL_BASE + 8'(idx);
            end
          end
          d.reg_a    = ra;
          d.reg_c    = rc;
          d.uses_lit = w[12];
          d.func     = {4'b0, fn7};
          if (w[12]) d.lit = w[20:13];
          else       d.reg_b = rb;
        end
      endcase
      return d;
    endfunction

    function void note_word(logic [31:0] w, logic [31:0] pos);
      decoded_t d;
      d = decode_word(w, pos);
      pending.push_back(d);
      words_seen++;
      kind_count[d.kind]++;
      if (d.mnem < 8'd16) mnem_count[d.mnem[3:0]]++;
      if (d.kind == KIND_INT && d.mnem == MN_UNDEF) int_no_match++;
    endfunction

    function void check_result(decoded_t got);
      decoded_t exp_d;
      logic     bad;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with no word outstanding: kind=%0d mn=%0d",
                   $realtime, got.kind, got.mnem);
        mismatches++;
        return;
      end
      exp_d = pending.pop_front();
      bad = (got.kind != exp_d.kind) || (got.mnem != exp_d.mnem) ||
            (got.reg_a != exp_d.reg_a) || (got.reg_b != exp_d.reg_b) ||
            (got.reg_c != exp_d.reg_c) || (got.uses_lit != exp_d.uses_lit) ||
            (got.lit != exp_d.lit) || (got.func != exp_d.func) ||
            (got.disp != exp_d.disp) || (got.target != exp_d.target);
      if (bad) begin
        if (mismatches < 10) begin
          $display("[%0t] mismatch exp: kind=%0d mn=%0d ra=%0d rb=%0d rc=%0d ls=%0d",
                   $realtime, exp_d.kind, exp_d.mnem, exp_d.reg_a, exp_d.reg_b,
                   exp_d.reg_c, exp_d.uses_lit);
          $display("             exp: lit=%h fn=%h disp=%h tgt=%h",
                   exp_d.lit, exp_d.func, exp_d.disp, exp_d.target);
          $display("             got: kind=%0d mn=%0d ra=%0d rb=%0d rc=%0d ls=%0d",
                   got.kind, got.mnem, got.reg_a, got.reg_b, got.reg_c, got.uses_lit);
          $display("             got: lit=%h fn=%h disp=%h tgt=%h",
                   got.lit, got.func, got.disp, got.target);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_instr_word = '0;
  logic [31:0]        in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic [7:0]         out_mnemonic;
  logic [4:0]         out_reg_a;
  logic [4:0]         out_reg_b;
  logic [4:0]         out_reg_c;
  logic               out_uses_literal;
  logic [7:0]         out_literal;
  logic [10:0]        out_func_code;
  logic signed [15:0] out_displacement;
  logic [31:0]        out_branch_target;

  decode_scoreboard sb;
  bit               full_rate = 1'b0;
  int               idle_cycles = 0;

  alpha_instruction_decoder_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instr_word     (in_instr_word),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_mnemonic      (out_mnemonic),
    .out_reg_a         (out_reg_a),
    .out_reg_b         (out_reg_b),
    .out_reg_c         (out_reg_c),
    .out_uses_literal  (out_uses_literal),
    .out_literal       (out_literal),
    .out_func_code     (out_func_code),
    .out_displacement  (out_displacement),
    .out_branch_target (out_branch_target)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none during full-rate stretches
  function automatic int pick_gap();
    int r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // present one word and hold it until the decoder takes it
  task automatic send_word(input logic [31:0] w, input logic [31:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_instr_word <= w;
    in_position   <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] int_word(logic [5:0] op, logic [4:0] ra, logic [4:0] rb,
                                           logic [6:0] fn, logic [4:0] rc);
    return {op, ra, rb, 3'b000, 1'b0, fn, rc};
  endfunction

  function automatic logic [31:0] fp_word(logic [5:0] op, logic [4:0] ra, logic [4:0] rb,
                                          logic [10:0] fn, logic [4:0] rc);
    return {op, ra, rb, fn, rc};
  endfunction

  // random word, biased toward well-formed encodings of each class
  task automatic make_random(output logic [31:0] w, output logic [31:0] pos);
    int          r;
    int          idx;
    logic [31:0] base;
    logic [5:0]  op;
    logic [4:0]  ra, rb, rc;
    logic [10:0] fn;
    base = $urandom;
    pos  = $urandom;
    r    = $urandom_range(0, 99);
    if (r < 15) begin
      w = base;
    end else if (r < 50) begin
      // operate word that hits a table entry
      idx = $urandom_range(0, NUM_ENTRIES - 1);
      op  = DECODE_TBL[idx][16:11];
      fn  = DECODE_TBL[idx][10:0];
      if (OPCODE_KIND[op] == KIND_FP) w = {op, base[25:16], fn, base[4:0]};
      else                            w = {op, base[25:12], fn[6:0], base[4:0]};
    end else if (r < 65) begin
      // register-copy alias candidates
      ra = $urandom_range(0, 1) ? REG_ZERO : 5'(base[25:21]);
      rb = ($urandom_range(0, 3) != 0) ? ra : 5'(base[20:16]);
      rc = $urandom_range(0, 1) ? REG_ZERO : 5'(base[4:0]);
      if ($urandom_range(0, 1))
        w = {OP_INTL, ra, rb, base[15:13], ($urandom_range(0, 3) == 0), FN_BIS, rc};
      else
        w = fp_word(OP_FLTL, ra, rb, FN_CPYS, rc);
    end else if (r < 75) begin
      // memory format, often the trap barrier candidate
      case ($urandom_range(0, 2))
        0:       op = OP_MISC;
        1:       op = 6'h08 + 6'($urandom_range(0, 7));
        default: op = 6'h20 + 6'($urandom_range(0, 15));
      endcase
      ra = $urandom_range(0, 1) ? 5'd0 : 5'(base[25:21]);
      rb = $urandom_range(0, 1) ? 5'd0 : 5'(base[20:16]);
      w  = {op, ra, rb, ($urandom_range(0, 1) ? 16'd0 : base[15:0])};
    end else if (r < 90) begin
      // branch with random or extreme position
      w = {6'h30 + 6'($urandom_range(0, 15)), base[25:0]};
      case ($urandom_range(0, 5))
        0:       pos = 32'd0;
        1:       pos = 32'hffff_fffc;
        2:       pos = 32'hffff_ffff;
        default: ;
      endcase
    end else begin
      w = {6'h1a, base[25:0]};
    end
  endtask

  // result side: random backpressure
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // monitor both handshakes and watch for a hung pipeline
  always @(posedge clk) begin
    decoded_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_instr_word, in_position);
      if (out_valid && out_ready) begin
        got.kind     = out_kind;
        got.mnem     = out_mnemonic;
        got.reg_a    = out_reg_a;
        got.reg_b    = out_reg_b;
        got.reg_c    = out_reg_c;
        got.uses_lit = out_uses_literal;
        got.lit      = out_literal;
        got.func     = out_func_code;
        got.disp     = out_displacement;
        got.target   = out_branch_target;
        sb.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] w;
    logic [31:0] pos;
    int          waited;
    int          total_errors;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every class and each alias rule
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'hffff_ffff, 32'hffff_ffff);
    send_word({OP_MISC, 26'd0}, 32'h1000);
    send_word({OP_MISC, 5'd0, 5'd0, 16'h0001}, 32'h1004);
    send_word({6'h08, 5'd3, 5'd31, 16'h8000}, 32'h2000);
    send_word({6'h2f, 5'd31, 5'd0, 16'h7fff}, 32'h2004);
    for (int h = 0; h < 4; h++)
      send_word({6'h1a, 5'd26, 5'd27, 2'(h), 14'h3abc}, 32'h3000);
    send_word(int_word(OP_INTL, REG_ZERO, REG_ZERO, FN_BIS, REG_ZERO), 32'h4000);
    send_word(int_word(OP_INTL, REG_ZERO, REG_ZERO, FN_BIS, 5'd5), 32'h4004);
    send_word(int_word(OP_INTL, 5'd7, 5'd7, FN_BIS, 5'd9), 32'h4008);
    send_word({OP_INTL, 5'd7, 8'hff, 1'b1, FN_BIS, 5'd9}, 32'h400c);
    send_word({OP_INTL, 5'd31, 8'h00, 1'b1, FN_BIS, 5'd31}, 32'h4010);
    send_word(int_word(OP_INTL, 5'd1, 5'd2, FN_BIS, 5'd3), 32'h4014);
    send_word(int_word(6'h10, 5'd4, 5'd5, 7'h7f, 5'd6), 32'h4018);
    send_word(int_word(6'h1c, 5'd8, 5'd9, 7'h01, 5'd10), 32'h401c);
    send_word(fp_word(OP_FLTL, REG_ZERO, REG_ZERO, FN_CPYS, REG_ZERO), 32'h5000);
    send_word(fp_word(OP_FLTL, 5'd4, 5'd4, FN_CPYS, REG_ZERO), 32'h5004);
    send_word(fp_word(OP_FLTL, 5'd4, 5'd5, FN_CPYS, 5'd6), 32'h5008);
    send_word(fp_word(6'h16, 5'd1, 5'd2, 11'h7ff, 5'd3), 32'h500c);
    send_word(fp_word(6'h16, 5'd0, 5'd31, 11'h5a7, 5'd0), 32'h5010);
    send_word({6'h30, 5'd1, 21'h0f_ffff}, 32'hffff_fff0);
    send_word({6'h39, 5'd2, 21'h10_0000}, 32'h0000_0000);
    send_word(32'h53ff_1fff, 32'h6000);
    send_word({6'h1b, 26'h3ff_efff}, 32'h6004);

    // random words, with full-rate stretches and one complete drain midway
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      full_rate = ((i % 400) >= 100) && ((i % 400) < 200);
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      make_random(w, pos);
      send_word(w, pos);
    end
    full_rate = 1'b0;
    in_valid <= 1'b0;

    // let the pipeline drain
    waited = 0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    total_errors = sb.mismatches + sb.pending.size();
    $display("decoded %0d words: undef %0d, jump %0d, memory %0d, branch %0d, int %0d, fp %0d",
             sb.words_seen, sb.kind_count[KIND_UNDEF], sb.kind_count[KIND_JUMP],
             sb.kind_count[KIND_MEM], sb.kind_count[KIND_BRANCH], sb.kind_count[KIND_INT],
             sb.kind_count[KIND_FP]);
    $display("trapb %0d nop %0d clr %0d mov %0d fnop %0d fmov %0d fp-unk %0d int-miss %0d",
             sb.mnem_count[MN_TRAPB], sb.mnem_count[MN_NOP], sb.mnem_count[MN_CLR],
             sb.mnem_count[MN_MOV], sb.mnem_count[MN_FNOP], sb.mnem_count[MN_FMOV],
             sb.mnem_count[MN_FP_UNKN], sb.int_no_match);
    if (total_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d words without a result", sb.mismatches, sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/aid_pkg.sv
hdl/aid_match.sv
hdl/alpha_instruction_decoder_top.sv
tb/alpha_instruction_decoder_top_test.sv
